// ===== rtl/nss_pkg.sv =====
package nss_pkg;

    localparam int CMD_W  = 3;
    localparam int NODE_W = 6;
    localparam int SYM_W  = 8;

    // Command codes as they arrive on the input
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MARK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BEGIN  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SYMBOL = 3'd4;

    typedef logic [2:0] op_t;

    // Decoded operations handed to the engine
    localparam op_t OP_CLEAR  = 3'd0;
    localparam op_t OP_LOAD   = 3'd1;
    localparam op_t OP_MARK   = 3'd2;
    localparam op_t OP_BEGIN  = 3'd3;
    localparam op_t OP_SYMBOL = 3'd4;
    localparam op_t OP_NOP    = 3'd5;

    typedef struct packed {
        op_t               op;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        logic [SYM_W-1:0]  sym;
        logic              eps;
        logic              src_ok;
        logic              dst_ok;
    } item_t;

    typedef struct packed {
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        logic [SYM_W-1:0]  sym;
        logic              eps;
    } edge_t;

    typedef struct packed {
        logic accepted;
        logic alive;
        logic overflow;
    } res_t;

endpackage

// ===== rtl/nss_front.sv =====
module nss_front #(
    parameter int NODES = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [nss_pkg::CMD_W-1:0]  cmd,
    input  logic [nss_pkg::NODE_W-1:0] src_node,
    input  logic [nss_pkg::NODE_W-1:0] dst_node,
    input  logic [nss_pkg::SYM_W-1:0]  symbol_byte,
    input  logic                       is_epsilon,
    output logic                       q_valid,
    output nss_pkg::item_t             q_item,
    input  logic                       q_pop
);
    import nss_pkg::*;

    localparam logic [NODE_W:0] NODES_C = (NODE_W + 1)'(NODES);

    item_t       fifo_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        push_ok;
    item_t       dec;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = fifo_reg[rd_ptr_reg];
    assign push_ok = push && !full;

    // Decode the command and check node ranges on the way in
    always_comb
    begin
        dec.src    = src_node;
        dec.dst    = dst_node;
        dec.sym    = symbol_byte;
        dec.eps    = is_epsilon;
        dec.src_ok = ({1'b0, src_node} < NODES_C);
        dec.dst_ok = ({1'b0, dst_node} < NODES_C);
        unique case (cmd)
            CMD_CLEAR:  dec.op = OP_CLEAR;
            CMD_LOAD:   dec.op = OP_LOAD;
            CMD_MARK:   dec.op = OP_MARK;
            CMD_BEGIN:  dec.op = OP_BEGIN;
            CMD_SYMBOL: dec.op = OP_SYMBOL;
            default:    dec.op = OP_NOP;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_ok)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (q_pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        priority if (push_ok && !q_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (q_pop && !push_ok)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            fifo_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// ===== rtl/nss_engine.sv =====
module nss_engine #(
    parameter int NODES = 64,
    parameter int EDGES = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [nss_pkg::NODE_W-1:0] start_state,
    input  logic                       q_valid,
    input  nss_pkg::item_t             q_item,
    output logic                       q_pop,
    output logic                       res_valid,
    output nss_pkg::res_t              res,
    input  logic                       res_pop
);
    import nss_pkg::*;

    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int AW = $clog2(EDGES);
    localparam int CW = $clog2(EDGES + 1);
    localparam logic [CW-1:0]     EDGES_C = CW'(EDGES);
    localparam logic [NODE_W:0]   NODES_C = (NODE_W + 1)'(NODES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SYM  = 2'd1;
    localparam logic [1:0] S_EPS  = 2'd2;

    edge_t            mem [EDGES];
    edge_t            rd_data_reg;
    edge_t            wr_data;
    logic             wr_en;
    logic             rd_en;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [CW-1:0]    addr_reg;
    logic [CW-1:0]    addr_next;
    logic             pend_reg;
    logic             pend_next;
    logic             changed_reg;
    logic             changed_next;
    logic [NODES-1:0] accept_reg;
    logic [NODES-1:0] accept_next;
    logic [NODES-1:0] active_reg;
    logic [NODES-1:0] active_next;
    logic [NODES-1:0] cur_reg;
    logic [NODES-1:0] cur_next;
    logic [SYM_W-1:0] sym_reg;
    logic [SYM_W-1:0] sym_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    res_t             res_reg;
    res_t             res_next;
    logic             finish;
    logic             ovf;
    logic             slot_free;
    logic             pass_done;
    logic [NW-1:0]    e_src;
    logic [NW-1:0]    e_dst;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign slot_free = !res_valid_reg || res_pop;
    assign pass_done = (addr_reg == count_reg) && !pend_reg;
    assign rd_en     = ((state_reg == S_SYM) || (state_reg == S_EPS)) && (addr_reg != count_reg);
    assign e_src     = rd_data_reg.src[NW-1:0];
    assign e_dst     = rd_data_reg.dst[NW-1:0];

    always_comb
    begin
        wr_data     = '{src: q_item.src, dst: q_item.dst,
                        sym: q_item.eps ? '0 : q_item.sym, eps: q_item.eps};
        state_next  = state_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        pend_next   = 1'b0;
        changed_next = changed_reg;
        accept_next = accept_reg;
        active_next = active_reg;
        cur_next    = cur_reg;
        sym_next    = sym_reg;
        q_pop       = 1'b0;
        wr_en       = 1'b0;
        finish      = 1'b0;
        ovf         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop = 1'b1;
                    unique case (q_item.op)
                        OP_CLEAR:
                        begin
                            count_next  = '0;
                            accept_next = '0;
                            active_next = '0;
                            finish      = 1'b1;
                        end
                        OP_LOAD:
                        begin
                            if (q_item.src_ok && q_item.dst_ok)
                            begin
                                if (count_reg == EDGES_C)
                                begin
                                    ovf = 1'b1;
                                end
                                else
                                begin
                                    wr_en      = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                            end
                            finish = 1'b1;
                        end
                        OP_MARK:
                        begin
                            if (q_item.dst_ok)
                            begin
                                accept_next[q_item.dst[NW-1:0]] = 1'b1;
                            end
                            finish = 1'b1;
                        end
                        OP_BEGIN:
                        begin
                            cur_next = '0;
                            if ({1'b0, start_state} < NODES_C)
                            begin
                                cur_next[start_state[NW-1:0]] = 1'b1;
                            end
                            addr_next    = '0;
                            changed_next = 1'b0;
                            state_next   = S_EPS;
                        end
                        OP_SYMBOL:
                        begin
                            cur_next   = '0;
                            sym_next   = q_item.sym;
                            addr_next  = '0;
                            state_next = S_SYM;
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            S_SYM, S_EPS:
            begin
                // Stream the edge table one entry a cycle
                if (rd_en)
                begin
                    addr_next = addr_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    if (state_reg == S_SYM)
                    begin
                        if (!rd_data_reg.eps && rd_data_reg.sym == sym_reg &&
                            active_reg[e_src])
                        begin
                            cur_next[e_dst] = 1'b1;
                        end
                    end
                    else if (rd_data_reg.eps && cur_reg[e_src] && !cur_reg[e_dst])
                    begin
                        cur_next[e_dst] = 1'b1;
                        changed_next    = 1'b1;
                    end
                end
                if (pass_done)
                begin
                    addr_next    = '0;
                    changed_next = 1'b0;
                    // Repeat closure passes until the set settles
                    if (state_reg == S_SYM || changed_reg)
                    begin
                        state_next = S_EPS;
                    end
                    else
                    begin
                        active_next = cur_reg;
                        state_next  = S_IDLE;
                        finish      = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_pop;
        if (finish)
        begin
            res_valid_next    = 1'b1;
            res_next.accepted = |(active_next & accept_next);
            res_next.alive    = |active_next;
            res_next.overflow = ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            changed_reg   <= 1'b0;
            accept_reg    <= '0;
            active_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            pend_reg      <= pend_next;
            changed_reg   <= changed_next;
            accept_reg    <= accept_next;
            active_reg    <= active_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        sym_reg <= sym_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr_reg[AW-1:0]];
        end
    end

endmodule

// ===== rtl/nfa_set_simulator_unit.sv =====
// NFA set simulator. Load edges, mark accepting nodes, then issue begin and
// one symbol command per input byte; every command beat yields one result
// beat with accepted, alive and overflow taken after the update. The edge
// table sits in a single-port-read memory scanned one edge per cycle, so
// clear, load_edge, mark_accept and unknown commands finish in the engine
// without a scan, while begin repeats epsilon passes (1 to NODES of them)
// over the loaded edges and symbol runs one symbol pass ahead of them,
// until the active set stops growing. A two-entry command
// queue lets the input side keep pushing while a result waits to be popped.
// No clearing pass is needed after reset. start_state is written through
// the cfg port, which is always ready.
module nfa_set_simulator_unit #(
    parameter int NODES = 64,
    parameter int EDGES = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [nss_pkg::CMD_W-1:0]  cmd,
    input  logic [nss_pkg::NODE_W-1:0] src_node,
    input  logic [nss_pkg::NODE_W-1:0] dst_node,
    input  logic [nss_pkg::SYM_W-1:0]  symbol_byte,
    input  logic                       is_epsilon,
    output logic                       empty,
    input  logic                       pop,
    output logic                       accepted,
    output logic                       alive,
    output logic                       overflow,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [nss_pkg::NODE_W-1:0] cfg_data
);
    import nss_pkg::*;

    logic [NODE_W-1:0] start_state_reg;
    logic              q_valid;
    item_t             q_item;
    logic              q_pop;
    logic              res_valid;
    res_t              res;
    logic              res_pop;

    assign cfg_ready = 1'b1;
    assign empty     = !res_valid;
    assign res_pop   = pop && res_valid;
    assign accepted  = res.accepted;
    assign alive     = res.alive;
    assign overflow  = res.overflow;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_state_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            start_state_reg <= cfg_data;
        end
    end

    nss_front #(
        .NODES(NODES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .src_node   (src_node),
        .dst_node   (dst_node),
        .symbol_byte(symbol_byte),
        .is_epsilon (is_epsilon),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    nss_engine #(
        .NODES(NODES),
        .EDGES(EDGES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_state(start_state_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .res_valid  (res_valid),
        .res        (res),
        .res_pop    (res_pop)
    );

    // Engine takes a command only from a non-empty queue
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("command queue popped while empty");

    // Engine takes a command only when the result slot is free
    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (empty || pop))
        else $error("command started with result slot occupied");

    // An accepting node can only be reported on a live set
    a_acc_alive: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && accepted) |-> alive)
        else $error("accepted reported with empty active set");

    // A pushed beat lands in the command queue
    a_push_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> q_valid)
        else $error("pushed command missing from queue");

endmodule

// ===== test/nfa_set_checker.sv =====
`timescale 1ns / 1ps

module nfa_set_checker #(
    parameter int NODES = 64,
    parameter int EDGES = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic                       full,
    input  logic [nss_pkg::CMD_W-1:0]  cmd,
    input  logic [nss_pkg::NODE_W-1:0] src_node,
    input  logic [nss_pkg::NODE_W-1:0] dst_node,
    input  logic [nss_pkg::SYM_W-1:0]  symbol_byte,
    input  logic                       is_epsilon,
    input  logic                       empty,
    input  logic                       pop,
    input  logic                       accepted,
    input  logic                       alive,
    input  logic                       overflow,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [nss_pkg::NODE_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         results_seen,
    output int                         pending,
    output int                         accept_hits,
    output int                         overflow_hits
);

    import nss_pkg::*;

    localparam int MAX_REPORTS = 20;

    edge_t             edge_tbl [EDGES];
    int                edge_cnt;
    logic [NODES-1:0]  accept_mask;
    logic [NODES-1:0]  active_mask;
    logic [NODE_W-1:0] start_node;
    res_t              due_q [$];

    initial
    begin
        edge_cnt      = 0;
        accept_mask   = '0;
        active_mask   = '0;
        start_node    = '0;
        fail_count    = 0;
        results_seen  = 0;
        pending       = 0;
        accept_hits   = 0;
        overflow_hits = 0;
    end

    // Repeat passes over the epsilon edges until the set stops growing
    function automatic logic [NODES-1:0] close_eps(input logic [NODES-1:0] seed);
        logic [NODES-1:0] cur;
        logic [NODES-1:0] nxt;
        bit               grew;
        cur  = seed;
        grew = 1'b1;
        while (grew)
        begin
            nxt = cur;
            for (int i = 0; i < edge_cnt; i++)
            begin
                if (edge_tbl[i].eps && cur[edge_tbl[i].src])
                    nxt[edge_tbl[i].dst] = 1'b1;
            end
            grew = (nxt != cur);
            cur  = nxt;
        end
        return cur;
    endfunction

    function automatic res_t apply_cmd(
        input logic [CMD_W-1:0]  c,
        input logic [NODE_W-1:0] s,
        input logic [NODE_W-1:0] d,
        input logic [SYM_W-1:0]  y,
        input logic              e
    );
        res_t             r;
        logic [NODES-1:0] nxt;
        r.overflow = 1'b0;
        nxt        = '0;
        case (c)
            CMD_CLEAR:
            begin
                edge_cnt    = 0;
                accept_mask = '0;
                active_mask = '0;
            end
            CMD_LOAD:
            begin
                if (s < NODES && d < NODES)
                begin
                    if (edge_cnt >= EDGES)
                        r.overflow = 1'b1;
                    else
                    begin
                        edge_tbl[edge_cnt].src = s;
                        edge_tbl[edge_cnt].dst = d;
                        // the label of an epsilon edge plays no part
                        edge_tbl[edge_cnt].sym = e ? '0 : y;
                        edge_tbl[edge_cnt].eps = e;
                        edge_cnt++;
                    end
                end
            end
            CMD_MARK:
            begin
                if (d < NODES)
                    accept_mask[d] = 1'b1;
            end
            CMD_BEGIN:
            begin
                if (start_node < NODES)
                    nxt[start_node] = 1'b1;
                active_mask = close_eps(nxt);
            end
            CMD_SYMBOL:
            begin
                for (int i = 0; i < edge_cnt; i++)
                begin
                    if (!edge_tbl[i].eps && edge_tbl[i].sym == y &&
                        active_mask[edge_tbl[i].src])
                        nxt[edge_tbl[i].dst] = 1'b1;
                end
                active_mask = close_eps(nxt);
            end
            default:
            begin
            end
        endcase
        r.accepted = |(active_mask & accept_mask);
        r.alive    = |active_mask;
        return r;
    endfunction

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: result %0d %s expected %b actual %b",
                         $time, results_seen, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : watch
        res_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                start_node = cfg_data;
            // retire first so a result can never pair with a same-edge command
            if (pop && !empty)
            begin
                if (due_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result %0d expected none actual %b%b%b",
                                 $time, results_seen, accepted, alive, overflow);
                end
                else
                begin
                    want = due_q.pop_front();
                    check_field("accepted", want.accepted, accepted);
                    check_field("alive", want.alive, alive);
                    check_field("overflow", want.overflow, overflow);
                    accept_hits   += want.accepted;
                    overflow_hits += want.overflow;
                end
                results_seen++;
            end
            if (push && !full)
                due_q.push_back(apply_cmd(cmd, src_node, dst_node, symbol_byte, is_epsilon));
            pending = due_q.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import nss_pkg::*;

    localparam int NODES    = 64;
    localparam int EDGES    = 256;
    localparam int LIMIT    = 3_000_000;
    localparam int RX_HOLD  = 400;
    localparam int N_RANDOM = 375;
    localparam int POOL_MAX = 8;

    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = 3'd7;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic [CMD_W-1:0]  cmd;
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
    logic [SYM_W-1:0]  symbol_byte;
    logic              is_epsilon;
    logic              empty;
    logic              pop;
    logic              accepted;
    logic              alive;
    logic              overflow;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [NODE_W-1:0] cfg_data;

    int fail_count;
    int results_seen;
    int pending;
    int accept_hits;
    int overflow_hits;

    int  items_sent;
    int  edges_loaded;
    int  start_writes;
    int  sessions;
    int  cycles;
    int  n_popped;
    int  rx_stall;
    bit  tx_quiet;
    bit  rx_quiet;
    int  pool_n;

    logic [NODE_W-1:0] pool  [POOL_MAX];
    logic [SYM_W-1:0]  alpha [3];

    nfa_set_simulator_unit #(
        .NODES (NODES),
        .EDGES (EDGES)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .src_node    (src_node),
        .dst_node    (dst_node),
        .symbol_byte (symbol_byte),
        .is_epsilon  (is_epsilon),
        .empty       (empty),
        .pop         (pop),
        .accepted    (accepted),
        .alive       (alive),
        .overflow    (overflow),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    nfa_set_checker #(
        .NODES (NODES),
        .EDGES (EDGES)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .cmd           (cmd),
        .src_node      (src_node),
        .dst_node      (dst_node),
        .symbol_byte   (symbol_byte),
        .is_epsilon    (is_epsilon),
        .empty         (empty),
        .pop           (pop),
        .accepted      (accepted),
        .alive         (alive),
        .overflow      (overflow),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .results_seen  (results_seen),
        .pending       (pending),
        .accept_hits   (accept_hits),
        .overflow_hits (overflow_hits)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= LIMIT)
            begin
                $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Result side: random stall before each pop, two long hold-offs to fill the block
    initial
    begin
        pop      = 1'b0;
        n_popped = 0;
        rx_quiet = 1'b0;
        rx_stall = $urandom_range(0, 15);
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                n_popped++;
                if (n_popped % 32 == 0)
                    rx_quiet = ($urandom_range(0, 3) == 0);
                if (n_popped == 40 || n_popped == 300)
                    rx_stall = RX_HOLD;
                else
                    rx_stall = rx_quiet ? 0 : $urandom_range(0, 15);
            end
            else if (rx_stall > 0)
                rx_stall--;
            pop <= (rx_stall == 0);
        end
    end

    function automatic logic [NODE_W-1:0] rnd_node();
        return NODE_W'($urandom);
    endfunction

    function automatic logic [SYM_W-1:0] rnd_sym();
        return SYM_W'($urandom);
    endfunction

    function automatic logic rnd_bit();
        return 1'($urandom);
    endfunction

    task automatic send_item(
        input logic [CMD_W-1:0]  c,
        input logic [NODE_W-1:0] s,
        input logic [NODE_W-1:0] d,
        input logic [SYM_W-1:0]  y,
        input logic              e
    );
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        cmd         <= c;
        src_node    <= s;
        dst_node    <= d;
        symbol_byte <= y;
        is_epsilon  <= e;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        if (c == CMD_CLEAR)
            edges_loaded = 0;
        else if (c == CMD_LOAD)
            edges_loaded++;
    endtask

    // Every command yields a result, so the block is idle once all have come back
    task automatic drain();
        push <= 1'b0;
        while (results_seen < items_sent)
            @(posedge clk);
    endtask

    task automatic write_start(input logic [NODE_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        start_writes++;
    endtask

    task automatic send_noise();
        logic [CMD_W-1:0] c;
        c = CMD_W'($urandom_range(CMD_LOAD, CMD_LAST_UNUSED));
        send_item(c, rnd_node(), rnd_node(), rnd_sym(), rnd_bit());
    endtask

    task automatic run_session(input bit fill);
        int                n_edges;
        int                n_syms;
        int                pick;
        logic [NODE_W-1:0] s0;
        logic [SYM_W-1:0]  y;
        tx_quiet = ($urandom_range(0, 3) == 0);
        pool_n   = $urandom_range(3, POOL_MAX);
        for (int k = 0; k < POOL_MAX; k++)
            pool[k] = rnd_node();
        for (int k = 0; k < 3; k++)
            alpha[k] = rnd_sym();
        if ($urandom_range(0, 3) != 0)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                s0 = '0;
            else if (pick == 1)
                s0 = '1;
            else if (pick == 2)
                s0 = rnd_node();
            else
                s0 = pool[$urandom_range(0, pool_n - 1)];
            write_start(s0);
        end
        if (fill || edges_loaded > 48 || $urandom_range(0, 3) != 0)
            send_item(CMD_CLEAR, rnd_node(), rnd_node(), rnd_sym(), rnd_bit());
        // a full fill runs past the table size to hit the overflow path
        n_edges = fill ? EDGES + 3 : $urandom_range(1, 12);
        for (int k = 0; k < n_edges; k++)
        begin
            if (!fill && $urandom_range(0, 9) == 0)
                send_noise();
            send_item(CMD_LOAD, pool[$urandom_range(0, pool_n - 1)],
                      pool[$urandom_range(0, pool_n - 1)], alpha[$urandom_range(0, 2)],
                      $urandom_range(0, fill ? 15 : 3) == 0);
        end
        for (int k = $urandom_range(1, 3); k > 0; k--)
            send_item(CMD_MARK, rnd_node(), pool[$urandom_range(0, pool_n - 1)],
                      rnd_sym(), rnd_bit());
        // now and then skip begin to run symbols on a stale or empty set
        if (fill || $urandom_range(0, 7) != 0)
            send_item(CMD_BEGIN, rnd_node(), rnd_node(), rnd_sym(), rnd_bit());
        n_syms = fill ? 4 : $urandom_range(2, 12);
        for (int k = 0; k < n_syms; k++)
        begin
            y = ($urandom_range(0, 7) == 0) ? rnd_sym() : alpha[$urandom_range(0, 2)];
            send_item(CMD_SYMBOL, rnd_node(), rnd_node(), y, rnd_bit());
            if (!fill && $urandom_range(0, 7) == 0)
                send_noise();
            if (!fill && $urandom_range(0, 11) == 0)
                send_item(CMD_BEGIN, rnd_node(), rnd_node(), rnd_sym(), rnd_bit());
        end
    endtask

    initial
    begin
        int base;
        int fill_at;
        rst_n        = 1'b0;
        push         = 1'b0;
        cmd          = CMD_CLEAR;
        src_node     = '0;
        dst_node     = '0;
        symbol_byte  = '0;
        is_epsilon   = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        items_sent   = 0;
        edges_loaded = 0;
        start_writes = 0;
        sessions     = 0;
        tx_quiet     = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_start('0);
        for (int u = CMD_FIRST_UNUSED; u <= CMD_LAST_UNUSED; u++)
            send_item(CMD_W'(u), rnd_node(), rnd_node(), rnd_sym(), rnd_bit());
        send_item(CMD_BEGIN, '1, '1, '1, 1'b1);
        send_item(CMD_SYMBOL, '0, '0, 8'h00, 1'b0);
        // eps label collides with a real label: only the real edge may fire
        send_item(CMD_LOAD, 6'd0, 6'd63, 8'hFF, 1'b1);
        send_item(CMD_LOAD, 6'd63, 6'd21, 8'hFF, 1'b0);
        send_item(CMD_LOAD, 6'd21, 6'd42, 8'h00, 1'b0);
        send_item(CMD_LOAD, 6'd42, 6'd42, 8'h00, 1'b1);
        send_item(CMD_LOAD, 6'd42, 6'd0, 8'h5A, 1'b1);
        send_item(CMD_MARK, '0, 6'd42, '0, 1'b0);
        send_item(CMD_MARK, '1, 6'd63, '1, 1'b1);
        send_item(CMD_BEGIN, '0, '0, '0, 1'b0);
        send_item(CMD_SYMBOL, '0, '0, 8'hFF, 1'b0);
        send_item(CMD_SYMBOL, '0, '0, 8'h00, 1'b0);
        send_item(CMD_SYMBOL, '0, '0, 8'h55, 1'b0);
        send_item(CMD_FIRST_UNUSED + 3'd1, '1, '1, '1, 1'b1);
        send_item(CMD_CLEAR, '1, '1, '1, 1'b1);
        send_item(CMD_BEGIN, '0, '0, '0, 1'b0);
        write_start('1);
        send_item(CMD_BEGIN, '0, '0, '0, 1'b0);
        send_item(CMD_LOAD, 6'd63, 6'd0, 8'h80, 1'b0);
        send_item(CMD_MARK, '0, 6'd0, '0, 1'b0);
        send_item(CMD_SYMBOL, '0, '0, 8'h80, 1'b0);
        send_item(CMD_CLEAR, '0, '0, '0, 1'b0);

        base    = items_sent;
        fill_at = $urandom_range(2, 6);
        while (items_sent - base < N_RANDOM)
        begin
            run_session(sessions == fill_at);
            sessions++;
        end

        drain();
        repeat (20) @(posedge clk);
        $display("Sent %0d commands in %0d random sessions, start node written %0d times.",
                 items_sent, sessions, start_writes);
        $display("Compared %0d results: %0d accepting, %0d table-full drops.",
                 results_seen, accept_hits, overflow_hits);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
